/* rtl/core/pwic_pkg.sv */
// Shared types and constants of the PID controller with integral clamp.
// Used by every module under rtl/core; depends on nothing else.
package pwic_pkg;

  // Default width of the internal error path.
  localparam int DATA_WIDTH_DEF = 32;

  // Port field widths (fixed by the stream format).
  localparam int FIELD_W      = 32;
  localparam int IN_TDATA_W   = 2 * FIELD_W;
  localparam int IN_TUSER_W   = 1;
  localparam int OUT_TDATA_W  = 2 * FIELD_W;
  localparam int OUT_TUSER_W  = 2;

  // Bit positions inside the result tuser.
  localparam int OUT_CLAMP_BIT = 0;
  localparam int OUT_SAT_BIT   = 1;

  // Configuration register file.
  localparam int GAIN_W     = 31;
  localparam int LIM_W      = 31;
  localparam int SUM_LIM_W  = 39;
  localparam int CFG_W      = 39;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN        = 3'd0,
    REG_INTEG_GAIN       = 3'd1,
    REG_DERIV_GAIN       = 3'd2,
    REG_INTEG_TERM_LIMIT = 3'd3,
    REG_INTEG_SUM_LIMIT  = 3'd4,
    REG_DRIVE_LIMIT      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]    prop_gain;
    logic [GAIN_W-1:0]    integ_gain;
    logic [GAIN_W-1:0]    deriv_gain;
    logic [LIM_W-1:0]     integ_term_limit;
    logic [SUM_LIM_W-1:0] integ_sum_limit;
    logic [LIM_W-1:0]     drive_limit;
  } cfg_t;

  // Q16.16 fraction.
  localparam int FRAC_W = 16;

  // Running error sum.
  localparam int SUM_W = 40;

  // Clamp threshold divider: quotient of {term limit, all-ones fraction} by the gain.
  localparam int QUO_W      = LIM_W + FRAC_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // Term magnitudes saturate at 2^60; signed terms and their total.
  localparam int TERM_MAG_W = 61;
  localparam int TERM_W     = TERM_MAG_W + 1;
  localparam int TOTAL_W    = TERM_W + 2;
  localparam logic [TERM_MAG_W-1:0] TERM_CAP = TERM_MAG_W'(1) << (TERM_MAG_W - 1);

  // Register stages inside one term unit (magnitude, partial products, combine).
  localparam int TERM_LAT = 3;

endpackage

/* rtl/core/pwic_cfg.sv */
// Configuration registers and the serial divider that turns the integral
// gain and term limit into a clamp threshold on the error sum. Uses pwic_pkg.
module pwic_cfg
  import pwic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output cfg_t                  cfg,
  output logic [QUO_W-1:0]      clamp_level,
  output logic                  busy
);

  logic                 restart;
  logic                 pending;
  logic [DIV_CNT_W-1:0] count;
  logic [GAIN_W-1:0]    rem;
  logic [QUO_W-1:0]     quo;
  logic [GAIN_W:0]      trial;
  logic [GAIN_W:0]      trial_sub;
  logic                 fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_PROP_GAIN:        cfg.prop_gain        <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN:       cfg.integ_gain       <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:       cfg.deriv_gain       <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_TERM_LIMIT: cfg.integ_term_limit <= cfg_wdata[LIM_W-1:0];
        REG_INTEG_SUM_LIMIT:  cfg.integ_sum_limit  <= cfg_wdata[SUM_LIM_W-1:0];
        REG_DRIVE_LIMIT:      cfg.drive_limit      <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_addr == REG_INTEG_GAIN ||
                              cfg_addr == REG_INTEG_TERM_LIMIT);

  // One restoring division step per cycle.
  assign trial     = {rem, quo[QUO_W-1]};
  assign trial_sub = trial - {1'b0, cfg.integ_gain};
  assign fits      = trial >= {1'b0, cfg.integ_gain};

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      count   <= '0;
    end else begin
      if (restart) begin
        pending <= 1'b1;
      end else begin
        pending <= 1'b0;
      end
      if (pending) begin
        count <= DIV_CNT_W'(DIV_STEPS);
      end else if (count != '0) begin
        count <= count - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      quo <= {cfg.integ_term_limit, {FRAC_W{1'b1}}};
      rem <= '0;
    end else if (count != '0) begin
      quo <= {quo[QUO_W-2:0], fits};
      rem <= fits ? trial_sub[GAIN_W-1:0] : trial[GAIN_W-1:0];
    end
  end

  assign clamp_level = quo;
  assign busy        = pending || (count != '0);

endmodule

/* rtl/core/pwic_loop.sv */
// Input register and the state loop: error, running sum with clamp
// decision, and derivative difference. Uses pwic_pkg.
module pwic_loop
  import pwic_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         take,
  input  logic                         action,
  input  logic [FIELD_W-1:0]           target,
  input  logic [FIELD_W-1:0]           measurement,
  input  cfg_t                         cfg,
  input  logic [QUO_W-1:0]             clamp_level,
  output logic                         valid_a,
  output logic signed [DATA_WIDTH-1:0] err_a,
  output logic signed [DATA_WIDTH:0]   dif_a,
  output logic signed [SUM_W-1:0]      sum_a,
  output logic                         clamp_a
);

  localparam int DW1  = DATA_WIDTH + 1;
  localparam int EXT  = (DATA_WIDTH > FIELD_W + 1) ? DATA_WIDTH : FIELD_W + 1;
  localparam int SEXT = ((DATA_WIDTH > SUM_W) ? DATA_WIDTH : SUM_W) + 1;
  localparam logic signed [EXT-1:0] EMAX =
    {{(EXT - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [EXT-1:0] EMIN =
    {{(EXT - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};
  localparam logic signed [SEXT-1:0] SMAX =
    {{(SEXT - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SEXT-1:0] SMIN =
    {{(SEXT - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};

  logic                         valid0;
  logic                         action0;
  logic [FIELD_W-1:0]           target0;
  logic [FIELD_W-1:0]           meas0;

  logic signed [SUM_W-1:0]      error_sum;
  logic signed [DATA_WIDTH-1:0] prev_error;

  logic signed [EXT-1:0]        raw;
  logic signed [EXT-1:0]        err_sat;
  logic signed [DATA_WIDTH-1:0] err;
  logic signed [SEXT-1:0]       sum_raw;
  logic signed [SUM_W-1:0]      sum_sat;
  logic                         sum_neg;
  logic [SUM_W-1:0]             sum_mag;
  logic                         clamp;
  logic signed [SUM_W-1:0]      sum_lim;
  logic signed [SUM_W-1:0]      sum_next;
  logic signed [DW1-1:0]        dif;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else if (advance) begin
      valid0 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action0 <= action;
      target0 <= target;
      meas0   <= measurement;
    end
  end

  always_comb begin
    raw = EXT'($signed(target0)) - EXT'($signed(meas0));
    priority if (raw > EMAX) begin
      err_sat = EMAX;
    end else if (raw < EMIN) begin
      err_sat = EMIN;
    end else begin
      err_sat = raw;
    end
    err = DATA_WIDTH'(err_sat);

    sum_raw = SEXT'(error_sum) + SEXT'(err);
    priority if (sum_raw > SMAX) begin
      sum_sat = SUM_W'(SMAX);
    end else if (sum_raw < SMIN) begin
      sum_sat = SUM_W'(SMIN);
    end else begin
      sum_sat = SUM_W'(sum_raw);
    end

    // Clamp when floor(gain * |sum| / 2^16) exceeds the term limit, which
    // is |sum| above the precomputed threshold.
    sum_neg = sum_sat[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-sum_sat) : SUM_W'(sum_sat);
    clamp   = (cfg.integ_gain != '0) && (QUO_W'(sum_mag) > clamp_level);
    sum_lim = $signed({1'b0, cfg.integ_sum_limit});
    if (clamp) begin
      sum_next = sum_neg ? -sum_lim : sum_lim;
    end else begin
      sum_next = sum_sat;
    end

    dif = DW1'(err) - DW1'(prev_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      prev_error <= '0;
      valid_a    <= 1'b0;
    end else if (advance) begin
      valid_a <= valid0;
      if (valid0) begin
        if (action0) begin
          error_sum  <= '0;
          prev_error <= '0;
        end else begin
          error_sum  <= sum_next;
          prev_error <= err;
        end
      end
    end
  end

  // A clear step leaves every field at zero, so later stages produce zeros.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (action0) begin
        err_a   <= '0;
        dif_a   <= '0;
        sum_a   <= '0;
        clamp_a <= 1'b0;
      end else begin
        err_a   <= err;
        dif_a   <= dif;
        sum_a   <= sum_sat;
        clamp_a <= clamp;
      end
    end
  end

  a_clear_zeroes_state: assert property (@(posedge clk) disable iff (rst)
    (advance && valid0 && action0) |=> (error_sum == '0 && prev_error == '0))
    else $error("state not cleared after a clear step");

endmodule

/* rtl/core/pwic_term.sv */
// One gain term: magnitude, split partial products, combine with the 2^60
// cap, optional clamp to a limit, sign restore. Three stages. Uses pwic_pkg.
module pwic_term
  import pwic_pkg::*;
#(
  parameter int VW = DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     advance,
  input  logic [GAIN_W-1:0]        gain,
  input  logic signed [VW-1:0]     value,
  input  logic                     clamp,
  input  logic [LIM_W-1:0]         limit,
  output logic signed [TERM_W-1:0] term
);

  localparam int MW = (VW > FRAC_W) ? VW : FRAC_W + 1;
  localparam int HW = MW - FRAC_W;
  localparam int PW = GAIN_W + HW;
  localparam int LW = GAIN_W + FRAC_W;
  localparam int TW = PW + 1;
  localparam int CW = (TW > TERM_MAG_W) ? TW : TERM_MAG_W;

  logic [VW-1:0]             mag_v;
  logic [MW-1:0]             mag_b;
  logic                      neg_b;
  logic                      clamp_b;
  logic [PW-1:0]             prod_hi;
  logic [LW-1:0]             prod_lo;
  logic                      neg_c;
  logic                      clamp_c;
  logic [TW-1:0]             sum_d;
  logic [TERM_MAG_W-1:0]     capped;
  logic signed [TERM_W-1:0]  mag_s;
  logic signed [TERM_W-1:0]  lim_s;

  assign mag_v = value[VW-1] ? VW'(-value) : VW'(value);

  always_ff @(posedge clk) begin
    if (advance) begin
      mag_b   <= MW'(mag_v);
      neg_b   <= value[VW-1];
      clamp_b <= clamp;
      prod_hi <= PW'(gain) * PW'(mag_b[MW-1:FRAC_W]);
      prod_lo <= LW'(gain) * LW'(mag_b[FRAC_W-1:0]);
      neg_c   <= neg_b;
      clamp_c <= clamp_b;
    end
  end

  // (g * m) >> 16 equals g * (m >> 16) + ((g * low16) >> 16).
  always_comb begin
    sum_d  = TW'(prod_hi) + TW'(prod_lo[LW-1:FRAC_W]);
    capped = (CW'(sum_d) > CW'(TERM_CAP)) ? TERM_CAP : TERM_MAG_W'(sum_d);
    mag_s  = $signed({1'b0, capped});
    lim_s  = $signed(TERM_W'(limit));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (clamp_c) begin
        term <= neg_c ? -lim_s : lim_s;
      end else begin
        term <= neg_c ? -mag_s : mag_s;
      end
    end
  end

endmodule

/* rtl/core/pwic_out.sv */
// Total of the three terms, output saturation and the result register,
// plus the delay line that keeps error and clamp flag aligned. Uses pwic_pkg.
module pwic_out
  import pwic_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         valid_a,
  input  logic signed [DATA_WIDTH-1:0] err_a,
  input  logic                         clamp_a,
  input  logic signed [TERM_W-1:0]     term_p,
  input  logic signed [TERM_W-1:0]     term_i,
  input  logic signed [TERM_W-1:0]     term_d,
  input  logic [LIM_W-1:0]             drive_limit,
  output logic                         m_valid,
  output logic [OUT_TDATA_W-1:0]       m_data,
  output logic [OUT_TUSER_W-1:0]       m_user
);

  localparam int DLY = TERM_LAT + 1;

  logic                         valid_d [DLY];
  logic signed [DATA_WIDTH-1:0] err_d   [DLY];
  logic                         clamp_d [DLY];
  logic signed [TOTAL_W-1:0]    total;
  logic signed [TOTAL_W-1:0]    lim_t;
  logic                         sat_hi;
  logic                         sat_lo;
  logic [FIELD_W-1:0]           drive;
  logic [FIELD_W-1:0]           lim_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLY; i++) begin
        valid_d[i] <= 1'b0;
      end
      m_valid <= 1'b0;
    end else if (advance) begin
      valid_d[0] <= valid_a;
      for (int i = 1; i < DLY; i++) begin
        valid_d[i] <= valid_d[i-1];
      end
      m_valid <= valid_d[DLY-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      err_d[0]   <= err_a;
      clamp_d[0] <= clamp_a;
      for (int i = 1; i < DLY; i++) begin
        err_d[i]   <= err_d[i-1];
        clamp_d[i] <= clamp_d[i-1];
      end
      total <= TOTAL_W'(term_p) + TOTAL_W'(term_i) + TOTAL_W'(term_d);
    end
  end

  always_comb begin
    lim_t  = $signed(TOTAL_W'(drive_limit));
    lim_f  = FIELD_W'(drive_limit);
    sat_hi = total > lim_t;
    sat_lo = total < -lim_t;
    priority if (sat_hi) begin
      drive = lim_f;
    end else if (sat_lo) begin
      drive = -lim_f;
    end else begin
      drive = total[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_data                <= {FIELD_W'(err_d[DLY-1]), drive};
      m_user[OUT_CLAMP_BIT] <= clamp_d[DLY-1];
      m_user[OUT_SAT_BIT]   <= sat_hi || sat_lo;
    end
  end

endmodule

/* rtl/core/pid_with_integral_clamp_unit.sv */
// Top level of the positional PID controller with integral anti-windup.
// Instantiates pwic_cfg, pwic_loop, three pwic_term units and pwic_out; uses pwic_pkg.

// Positional PID controller in signed Q16.16. Each input beat carries a target
// and a measurement (tdata) and an action flag (tuser): a compute step forms the
// saturated error, adds it to a 40-bit running sum and returns
// drive = kp*e + ki*sum + kd*(e - previous e), where the integral term is held
// to plus or minus its limit (the sum is then reloaded with the configured sum
// limit of the same sign) and the total is held to plus or minus the drive
// limit. A clear step zeroes the sum and the previous error and returns an
// all-zero result. Every input beat gives exactly one result beat. The block
// takes one beat per clock cycle unless the output is held or the divider is
// busy; the state update (error, sum and clamp decision) is a single registered
// stage, and the three multiplications sit in their own stages after it. The
// integral clamp compares the sum against a threshold that a one-bit-per-cycle
// divider derives from the integral gain and term limit: after a write to either
// register the input is not ready until the divider is done. Other register
// writes take effect at once; configure only while the block is idle.
module pid_with_integral_clamp_unit
  import pwic_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] target, [63:32] measurement
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [0] action: 0 compute, 1 clear
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] drive, [63:32] error_now
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] integ_clamped, [1] drive_saturated
  // Configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  cfg_t                         cfg;
  logic [QUO_W-1:0]             clamp_level;
  logic                         busy;
  logic                         advance;
  logic                         take;
  logic                         valid_a;
  logic signed [DATA_WIDTH-1:0] err_a;
  logic signed [DATA_WIDTH:0]   dif_a;
  logic signed [SUM_W-1:0]      sum_a;
  logic                         clamp_a;
  logic signed [TERM_W-1:0]     term_p;
  logic signed [TERM_W-1:0]     term_i;
  logic signed [TERM_W-1:0]     term_d;

  // The whole pipeline moves together; it halts only when a finished result
  // sits in the output register and the sink does not take it.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance && !busy;
  assign take          = s_axis_tvalid && s_axis_tready;

  pwic_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .cfg         (cfg),
    .clamp_level (clamp_level),
    .busy        (busy)
  );

  pwic_loop #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_loop (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .take        (take),
    .action      (s_axis_tuser[0]),
    .target      (s_axis_tdata[FIELD_W-1:0]),
    .measurement (s_axis_tdata[IN_TDATA_W-1:FIELD_W]),
    .cfg         (cfg),
    .clamp_level (clamp_level),
    .valid_a     (valid_a),
    .err_a       (err_a),
    .dif_a       (dif_a),
    .sum_a       (sum_a),
    .clamp_a     (clamp_a)
  );

  // Proportional term on the error.
  pwic_term #(
    .VW (DATA_WIDTH)
  ) u_term_p (
    .clk     (clk),
    .advance (advance),
    .gain    (cfg.prop_gain),
    .value   (err_a),
    .clamp   (1'b0),
    .limit   ('0),
    .term    (term_p)
  );

  // Integral term on the running sum, held to the term limit when clamped.
  pwic_term #(
    .VW (SUM_W)
  ) u_term_i (
    .clk     (clk),
    .advance (advance),
    .gain    (cfg.integ_gain),
    .value   (sum_a),
    .clamp   (clamp_a),
    .limit   (cfg.integ_term_limit),
    .term    (term_i)
  );

  // Derivative term on the change of error.
  pwic_term #(
    .VW (DATA_WIDTH + 1)
  ) u_term_d (
    .clk     (clk),
    .advance (advance),
    .gain    (cfg.deriv_gain),
    .value   (dif_a),
    .clamp   (1'b0),
    .limit   ('0),
    .term    (term_d)
  );

  pwic_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .valid_a     (valid_a),
    .err_a       (err_a),
    .clamp_a     (clamp_a),
    .term_p      (term_p),
    .term_i      (term_i),
    .term_d      (term_d),
    .drive_limit (cfg.drive_limit),
    .m_valid     (m_axis_tvalid),
    .m_data      (m_axis_tdata),
    .m_user      (m_axis_tuser)
  );

  a_no_take_while_dividing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready)
    else $error("input ready while the clamp threshold is being computed");

  a_ready_only_when_moving: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input ready while the pipeline is held");

  a_reset_empties_output: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

endmodule

/* test/tb_pid_with_integral_clamp_unit.sv */
// Self-checking testbench for pid_with_integral_clamp_unit.
// It needs pwic_pkg and the RTL under rtl/core and nothing else. Stimulus,
// prediction and checking are all in this file.

module tb_pid_with_integral_clamp_unit;
  import pwic_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  // Enough to let the pipeline empty before a register write and before the report.
  localparam int SETTLE_CYCLES  = 12;
  localparam int TIMEOUT_CYCLES = 500_000;

  // Action flag carried in s_axis_tuser.
  localparam bit ACT_STEP  = 1'b0;
  localparam bit ACT_CLEAR = 1'b1;

  // Addresses past the last register. Writes to them must change nothing.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  // Saturation bounds of the error and of the running sum.
  localparam longint ERR_HI = (longint'(1) <<< (DATA_WIDTH_DEF - 1)) - 1;
  localparam longint ERR_LO = -(longint'(1) <<< (DATA_WIDTH_DEF - 1));
  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));
  localparam bit [63:0] PRODUCT_CAP = 64'(TERM_CAP);

  typedef struct {
    bit              action;
    bit [FIELD_W-1:0] target;
    bit [FIELD_W-1:0] measurement;
  } pid_step_t;

  typedef struct packed {
    bit [FIELD_W-1:0] drive;
    bit [FIELD_W-1:0] error_now;
    bit               integ_clamped;
    bit               drive_saturated;
  } pid_result_t;

  // All inputs of the block start at known values.
  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] target, [63:32] measurement
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // [0] action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [31:0] drive, [63:32] error_now
  logic [OUT_TUSER_W-1:0] m_axis_tuser;        // [0] integ_clamped, [1] drive_saturated
  logic                   cfg_we        = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
  logic [CFG_W-1:0]       cfg_wdata     = '0;

  // Steps waiting to be sent, and results still owed by the block.
  pid_step_t   steps_to_send[$];
  pid_result_t results_due[$];
  pid_step_t   cur_step;

  int fail_count    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Our own copy of the controller: its registers and its state.
  bit [63:0] kp_gain, ki_gain, kd_gain, iterm_cap, sum_restore, drive_cap;
  longint    err_acc  = 0;
  longint    last_err = 0;

  pid_with_integral_clamp_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic bit [63:0] magnitude(longint x);
    bit [63:0] u;
    u = x;
    return (x < 0) ? -u : u;
  endfunction

  // Gain times magnitude in Q16.16, truncated and capped at 2^60. The split
  // into whole and fractional parts keeps every product inside 64 bits.
  function automatic bit [63:0] scaled_mag(bit [63:0] g, bit [63:0] m);
    bit [63:0] whole, frac, r;
    whole = m >> FRAC_W;
    frac  = m & 64'hFFFF;
    if (g != 0 && whole > PRODUCT_CAP / g) return PRODUCT_CAP;
    r = g * whole + ((g * frac) >> FRAC_W);
    return (r > PRODUCT_CAP) ? PRODUCT_CAP : r;
  endfunction

  // The sign is applied after scaling, so each term rounds toward zero.
  function automatic longint gain_term(bit [63:0] g, longint x);
    longint r;
    r = longint'(scaled_mag(g, magnitude(x)));
    return (x < 0) ? -r : r;
  endfunction

  function automatic pid_result_t compute_pid_step(pid_step_t st);
    longint      err, sum, p_term, i_term, d_term, total;
    pid_result_t res;
    res = '0;
    if (st.action == ACT_CLEAR) begin
      err_acc  = 0;
      last_err = 0;
      return res;
    end
    err = longint'($signed(st.target)) - longint'($signed(st.measurement));
    if (err > ERR_HI) err = ERR_HI;
    if (err < ERR_LO) err = ERR_LO;
    sum = err_acc + err;
    if (sum > SUM_HI) sum = SUM_HI;
    if (sum < SUM_LO) sum = SUM_LO;
    p_term = gain_term(kp_gain, err);
    i_term = gain_term(ki_gain, sum);
    d_term = gain_term(kd_gain, err - last_err);
    // Anti-windup: hold the integral term and reload the sum, keeping its sign.
    if (magnitude(i_term) > iterm_cap) begin
      res.integ_clamped = 1'b1;
      if (i_term > 0) begin
        i_term = longint'(iterm_cap);
        sum    = longint'(sum_restore);
      end else begin
        i_term = -longint'(iterm_cap);
        sum    = -longint'(sum_restore);
      end
    end
    total = p_term + i_term + d_term;
    if (magnitude(total) > drive_cap) begin
      res.drive_saturated = 1'b1;
      total = (total >= 0) ? longint'(drive_cap) : -longint'(drive_cap);
    end
    err_acc       = sum;
    last_err      = err;
    res.drive     = total[FIELD_W-1:0];
    res.error_now = err[FIELD_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes steps from the queue and offers them on the input stream.
  // The expected result is worked out at the edge at which the beat is taken.
  // A new beat is loaded only when the slot is free or being emptied, so
  // tvalid gets at most one assignment per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(compute_pid_step(cur_step));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (steps_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_step = steps_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_step.measurement, cur_step.target};
          s_axis_tuser  <= cur_step.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares every result beat with the oldest expectation and
  // stalls the result stream at random.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, bit [FIELD_W-1:0] want,
                                      logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    pid_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $error("result beat with nothing expected: tdata %h tuser %b",
                 m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("drive", want.drive, m_axis_tdata[FIELD_W-1:0]);
          check_field("error_now", want.error_now, m_axis_tdata[2*FIELD_W-1:FIELD_W]);
          check_field("integ_clamped", FIELD_W'(want.integ_clamped),
                      FIELD_W'(m_axis_tuser[OUT_CLAMP_BIT]));
          check_field("drive_saturated", FIELD_W'(want.drive_saturated),
                      FIELD_W'(m_axis_tuser[OUT_SAT_BIT]));
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes. The enable is lowered once the whole set has gone in. Our
  // copy is updated as the write is issued, which is safe because writes only
  // happen while the block is idle.
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, bit [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    case (addr)
      REG_PROP_GAIN:        kp_gain     = 64'(value[GAIN_W-1:0]);
      REG_INTEG_GAIN:       ki_gain     = 64'(value[GAIN_W-1:0]);
      REG_DERIV_GAIN:       kd_gain     = 64'(value[GAIN_W-1:0]);
      REG_INTEG_TERM_LIMIT: iterm_cap   = 64'(value[LIM_W-1:0]);
      REG_INTEG_SUM_LIMIT:  sum_restore = 64'(value[SUM_LIM_W-1:0]);
      REG_DRIVE_LIMIT:      drive_cap   = 64'(value[LIM_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_settings(bit [GAIN_W-1:0] p, bit [GAIN_W-1:0] i,
                                bit [GAIN_W-1:0] d, bit [LIM_W-1:0] tl,
                                bit [SUM_LIM_W-1:0] sl, bit [LIM_W-1:0] dl,
                                bit poke_spare);
    write_reg(REG_PROP_GAIN, CFG_W'(p));
    write_reg(REG_INTEG_GAIN, CFG_W'(i));
    write_reg(REG_DERIV_GAIN, CFG_W'(d));
    write_reg(REG_INTEG_TERM_LIMIT, CFG_W'(tl));
    write_reg(REG_INTEG_SUM_LIMIT, CFG_W'(sl));
    write_reg(REG_DRIVE_LIMIT, CFG_W'(dl));
    if (poke_spare) begin
      write_reg(REG_SPARE_LO, '1);
      write_reg(REG_SPARE_HI, '1);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom_range(0, 32'h3FFFF));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic bit [LIM_W-1:0] pick_limit();
    return LIM_W'($urandom) >> $urandom_range(0, LIM_W - 1);
  endfunction

  // With a non-zero gain, half the time the sum limit is the clamp threshold
  // (term limit over gain); otherwise it is any value, including the largest.
  function automatic bit [SUM_LIM_W-1:0] pick_sum_limit(bit [GAIN_W-1:0] ki,
                                                         bit [LIM_W-1:0] tl);
    bit [63:0] q;
    if (ki != 0 && $urandom_range(0, 1) == 1) begin
      q = {17'd0, tl, 16'hFFFF} / 64'(ki);
      return (q > 64'(SUM_HI)) ? '1 : SUM_LIM_W'(q);
    end
    if ($urandom_range(0, 5) == 0) return '1;
    return SUM_LIM_W'({$urandom, $urandom});
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_step(bit act, bit [FIELD_W-1:0] tg, bit [FIELD_W-1:0] ms);
    steps_to_send.push_back('{act, tg, ms});
  endtask

  // Error extremes, both saturation directions, sign changes for the
  // derivative, truncation of single-LSB errors, clamping in both directions
  // and clear steps part-way through a sequence.
  task automatic queue_directed_steps();
    queue_step(ACT_CLEAR, $urandom, $urandom);
    queue_step(ACT_STEP, 32'h0000_0000, 32'h0000_0000);
    queue_step(ACT_STEP, 32'h0001_0000, 32'h0000_0000);
    queue_step(ACT_STEP, 32'h0000_0000, 32'h0001_0000);
    queue_step(ACT_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_step(ACT_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_step(ACT_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_step(ACT_STEP, 32'h8000_0000, 32'h0000_0000);
    queue_step(ACT_STEP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_step(ACT_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_step(ACT_CLEAR, 32'h0000_0000, 32'h0000_0000);
    queue_step(ACT_STEP, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_step(ACT_STEP, 32'h0000_0001, 32'h0000_0000);
    queue_step(ACT_STEP, 32'h0000_8000, 32'h0000_4000);
    queue_step(ACT_STEP, 32'h1234_5678, 32'h1234_5678);
    queue_step(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (4) queue_step(ACT_STEP, 32'h0010_0000, 32'h0000_0000);
    queue_step(ACT_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_step(ACT_STEP, 32'h8000_0000, 32'h8000_0000);
  endtask

  // Mostly tracking runs: a fixed set point with the measurement either
  // settling towards it or sitting at a steady offset, which winds the
  // integral up. The rest are noise beats and clear steps. With long_runs set
  // the runs are a few hundred beats of saturated error of alternating sign,
  // long enough to drive the running sum into its own saturation.
  task automatic queue_random_steps(int count, bit long_runs);
    int               left, pick;
    bit               pos, shrink, act;
    bit [FIELD_W-1:0] setpt, tg, ms;
    longint           dev;
    left   = 0;
    pos    = $urandom_range(0, 1);
    shrink = 1'b0;
    setpt  = '0;
    dev    = 0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      act  = ACT_STEP;
      tg   = $urandom;
      ms   = $urandom;
      if (!long_runs && pick < 6) begin
        act = ACT_CLEAR;
      end else if (pick < 16) begin
        // Noise beat: both fields fully random.
      end else if (long_runs) begin
        if (left == 0) begin
          left = $urandom_range(270, 300);
          pos  = !pos;
        end
        left--;
        tg = pos ? {16'h7FFF, tg[15:0]} : {16'h8000, tg[15:0]};
        ms = pos ? {16'h8000, ms[15:0]} : {16'h7FFF, ms[15:0]};
      end else begin
        if (left == 0) begin
          left   = $urandom_range(3, 40);
          setpt  = $urandom;
          dev    = longint'($signed($urandom)) >>> $urandom_range(0, 31);
          shrink = $urandom_range(0, 1);
        end
        left--;
        tg  = setpt;
        ms  = setpt - dev[FIELD_W-1:0];
        dev = shrink ? dev - (dev >>> 2) : dev;
        dev = dev + longint'($urandom_range(0, 64)) - 32;
      end
      queue_step(act, tg, ms);
    end
  endtask

  // Sampled on the falling edge so that the queues and tvalid have settled.
  task automatic wait_until_idle();
    @(negedge clk);
    while (steps_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    int                 ph;
    bit [GAIN_W-1:0]    p, i, d;
    bit [LIM_W-1:0]     tl, dl;
    bit [SUM_LIM_W-1:0] sl;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Nine phases, each with its own register set. Every phase ends with the
    // sender holding off until all results are back, so the block is idle
    // whenever the registers change. Idling: sender light and receiver heavy
    // first, then the reverse, then none at all.
    for (ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 74;
      end else if (ph < 6) begin
        send_idle_pct = 74;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (ph)
        // Unity proportional gain, quarter integral, half derivative; the sum
        // limit matches the term limit in the first, is the maximum in the
        // second.
        0: apply_settings(31'h1_0000, 31'h4000, 31'h8000, 31'h0100_0000,
                          39'h0400_0000, 31'h4000_0000, 1'b0);
        1: apply_settings(31'h1_0000, 31'h4000, 31'h8000, 31'h0100_0000,
                          '1, 31'h4000_0000, 1'b0);
        // Everything at its largest.
        2: apply_settings('1, '1, '1, '1, '1, '1, 1'b0);
        // Largest gains against zero limits: anything non-zero clamps.
        3: apply_settings('1, '1, '1, '0, '0, '0, 1'b0);
        // Small integral gain and wide limits so the sum can saturate.
        4: apply_settings(31'h100, 31'h80, 31'h100, '1, '1, '1, 1'b0);
        default: begin
          p  = pick_gain();
          i  = pick_gain();
          d  = pick_gain();
          tl = pick_limit();
          dl = pick_limit();
          sl = pick_sum_limit(i, tl);
          apply_settings(p, i, d, tl, sl, dl, ph == 5);
        end
      endcase
      @(negedge clk);
      if (ph == 0) queue_directed_steps();
      else queue_random_steps((ph == 4) ? 600 : 105, ph == 4);
    end

    wait_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* pid_with_integral_clamp_unit.f */
rtl/core/pwic_pkg.sv
rtl/core/pwic_cfg.sv
rtl/core/pwic_loop.sv
rtl/core/pwic_term.sv
rtl/core/pwic_out.sv
rtl/core/pid_with_integral_clamp_unit.sv
test/tb_pid_with_integral_clamp_unit.sv
